// File: rtl/ica_pkg.sv
`timescale 1ns / 1ps

package ica_pkg;

    // default parameter values
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // register map
    localparam logic [1:0] REG_BLEND  = 2'd0;
    localparam logic [1:0] REG_BIAS_X = 2'd1;
    localparam logic [1:0] REG_BIAS_Y = 2'd2;
    localparam logic [1:0] REG_BIAS_Z = 2'd3;

    localparam logic [16:0] BLEND_RESET = 17'd64225;
    localparam logic [16:0] ALPHA_ONE   = 17'd65536;

    // pi/2 in Q2.30
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GMUL,
        S_GACC,
        S_SQMUL,
        S_SQACC,
        S_CHK,
        S_ROOT,
        S_ROOTW,
        S_CORD,
        S_CORDW,
        S_LOAD,
        S_BMUL0,
        S_BMUL1,
        S_BACC,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        CD_IDLE,
        CD_NORM,
        CD_ITER
    } cd_state_t;

    // handshake between sequencer and a multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // atan(2^-i) in Q2.30, rounded down
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd7;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // saturate to 32 bit signed
    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -52'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: rtl/ica_isqrt.sv
`timescale 1ns / 1ps

// floor square root of a 64 bit value, one result bit per cycle
module ica_isqrt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [63:0]          radicand,
    output ica_pkg::unit_stat_t  stat,
    output logic [31:0]          root
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] n_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= radicand;
            res_reg <= 64'd0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = res_reg[31:0];

endmodule

// File: rtl/ica_cordic.sv
`timescale 1ns / 1ps

// vectoring CORDIC: atan2(y0, c) in [0, pi], rounded to FRAC_BITS
module ica_cordic #(
    parameter int FRAC_BITS    = ica_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = ica_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [31:0]   c,
    input  logic [32:0]          y0,
    output ica_pkg::unit_stat_t  stat,
    output logic signed [31:0]   angle
);

    localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int W     = 46;
    localparam logic signed [W-1:0]  NORM_LIM = W'(64'd1 << 40);
    localparam logic signed [35:0]   Z_ROUND  = 36'sd1 <<< (29 - FRAC_BITS);
    localparam logic [5:0]           LAST_I   = 6'(STEPS - 1);

    ica_pkg::cd_state_t st_reg, st_next;
    logic                done_reg, done_next;
    logic signed [W-1:0] x_reg, x_next;
    logic signed [W-1:0] y_reg, y_next;
    logic signed [35:0]  z_reg, z_next;
    logic [5:0]          i_reg, i_next;

    logic signed [W-1:0] y_abs;
    logic signed [W-1:0] mag;
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic signed [35:0]  at;
    logic signed [35:0]  z_rnd;

    assign y_abs = (y_reg < 0) ? -y_reg : y_reg;
    assign mag   = (x_reg > y_abs) ? x_reg : y_abs;
    assign xs    = x_reg >>> i_reg[4:0];
    assign ys    = y_reg >>> i_reg[4:0];
    assign at    = {6'd0, ica_pkg::atan_q30(i_reg[4:0])};

    // next state and datapath
    always_comb
    begin
        st_next   = st_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        unique case (st_reg)
            ica_pkg::CD_IDLE:
            begin
                if (start)
                begin
                    // negative c: pre-rotate by pi/2 so x starts non-negative
                    if (c < 0)
                    begin
                        x_next = W'($signed({1'b0, y0}));
                        y_next = -W'(c);
                        z_next = ica_pkg::HALF_PI_Q30;
                    end
                    else
                    begin
                        x_next = W'(c);
                        y_next = W'($signed({1'b0, y0}));
                        z_next = 36'sd0;
                    end
                    i_next  = 6'd0;
                    st_next = ica_pkg::CD_NORM;
                end
            end
            ica_pkg::CD_NORM:
            begin
                // scale up one bit a cycle until near the top of the range
                if ((mag == 0) || (mag >= NORM_LIM))
                    st_next = ica_pkg::CD_ITER;
                else
                begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end
            end
            ica_pkg::CD_ITER:
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end
                i_next = i_reg + 6'd1;
                if (i_reg == LAST_I)
                begin
                    st_next   = ica_pkg::CD_IDLE;
                    done_next = 1'b1;
                end
            end
            default:
            begin
                st_next = ica_pkg::CD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ica_pkg::CD_IDLE;
            done_reg <= 1'b0;
            i_reg    <= 6'd0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign z_rnd     = z_reg + Z_ROUND;
    assign angle     = 32'(z_rnd >>> (30 - FRAC_BITS));
    assign stat.busy = (st_reg != ica_pkg::CD_IDLE);
    assign stat.done = done_reg;

endmodule

// File: rtl/imu_complementary_attitude.sv
`timescale 1ns / 1ps

// Complementary-filter attitude estimator. One word in, one word out; the
// block takes no new word while one is in work. A word with neither sample
// goes straight to the output; the gyro update integrates each axis, and an
// accel update forms the squared magnitude, then for each of the three axes
// runs the bit-serial square root, CORDIC pre-scaling and CORDIC_STEPS
// rotations, then loads the angles or blends them. The square root and
// CORDIC units and one 34x34 multiplier are shared by all axes under one
// sequencer. A finished word waits in the output register while the next
// word is accepted.
module imu_complementary_attitude #(
    parameter int FRAC_BITS    = ica_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = ica_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // config
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               gyro_valid,
    input  logic signed [31:0] gyro_x,
    input  logic signed [31:0] gyro_y,
    input  logic signed [31:0] gyro_z,
    input  logic [15:0]        step_time,
    input  logic               accel_valid,
    input  logic signed [31:0] accel_x,
    input  logic signed [31:0] accel_y,
    input  logic signed [31:0] accel_z,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] roll_angle,
    output logic signed [31:0] pitch_angle,
    output logic signed [31:0] yaw_angle,
    output logic               accel_fault,
    output logic               accel_seen
);

    // axis slots: 0 roll (accel x, gyro z), 1 yaw (accel y, gyro y),
    // 2 pitch (accel z, gyro x negated)
    ica_pkg::state_t    st_reg, st_next;
    logic [1:0]         k_reg, k_next;
    logic signed [31:0] ang_reg [3];
    logic signed [31:0] ang_next [3];
    logic signed [31:0] nang_reg [3];
    logic signed [31:0] nang_next [3];
    logic [63:0]        sq_reg [3];
    logic [63:0]        sq_next [3];
    logic [63:0]        sumsq_reg, sumsq_next;
    logic signed [49:0] bsum_reg, bsum_next;
    logic               seen_reg, seen_next;
    logic               fault_reg, fault_next;
    logic signed [67:0] prod_reg;

    // latched input word
    logic               gv_reg, av_reg;
    logic signed [31:0] gx_reg, gy_reg, gz_reg;
    logic signed [31:0] ax_reg, ay_reg, az_reg;
    logic [15:0]        dt_reg;

    // output register
    logic               ov_reg, ov_next;
    logic signed [31:0] roll_reg, pitch_reg, yaw_reg;
    logic               of_reg, os_reg;
    logic               out_load;

    // config registers
    logic [16:0]        bw_reg;
    logic signed [31:0] bx_reg, by_reg, bz_reg;

    logic               accept;
    logic               sqrt_start, cord_start;
    ica_pkg::unit_stat_t sqrt_stat, cord_stat;
    logic [31:0]        root;
    logic signed [31:0] cord_angle;

    logic signed [33:0] mul_a, mul_b;
    logic signed [31:0] rate_sel, bias_sel, acc_sel;
    logic signed [32:0] diff;
    logic [16:0]        alpha, alpha_c;
    logic signed [51:0] delta, gsum, bsum_r;
    logic signed [49:0] bsum_tot;

    assign accept = in_valid && in_ready;
    assign pready = 1'b1;

    // operand selects
    always_comb
    begin
        case (k_reg)
            2'd0:    begin rate_sel = gz_reg; bias_sel = bz_reg; acc_sel = ax_reg; end
            2'd1:    begin rate_sel = gy_reg; bias_sel = by_reg; acc_sel = ay_reg; end
            default: begin rate_sel = gx_reg; bias_sel = bx_reg; acc_sel = az_reg; end
        endcase
    end

    assign diff    = 33'(rate_sel) - 33'(bias_sel);
    assign alpha   = (bw_reg > ica_pkg::ALPHA_ONE) ? ica_pkg::ALPHA_ONE : bw_reg;
    assign alpha_c = ica_pkg::ALPHA_ONE - alpha;

    // shared multiplier, registered product
    always_comb
    begin
        mul_a = 34'sd0;
        mul_b = 34'sd0;
        case (st_reg)
            ica_pkg::S_GMUL:
            begin
                mul_a = 34'(diff);
                mul_b = $signed({18'd0, dt_reg});
            end
            ica_pkg::S_SQMUL:
            begin
                mul_a = 34'(acc_sel);
                mul_b = 34'(acc_sel);
            end
            ica_pkg::S_BMUL0:
            begin
                mul_a = 34'(ang_reg[k_reg]);
                mul_b = $signed({17'd0, alpha});
            end
            ica_pkg::S_BMUL1:
            begin
                mul_a = 34'(nang_reg[k_reg]);
                mul_b = $signed({17'd0, alpha_c});
            end
            default:
            begin
                mul_a = 34'sd0;
                mul_b = 34'sd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // rounding and accumulation
    assign delta    = ($signed(prod_reg[51:0]) + 52'sd32768) >>> 16;
    assign gsum     = 52'(ang_reg[k_reg]) + ((k_reg == 2'd2) ? -delta : delta);
    assign bsum_tot = bsum_reg + prod_reg[49:0];
    assign bsum_r   = (52'(bsum_tot) + 52'sd32768) >>> 16;

    assign out_load = (st_reg == ica_pkg::S_DONE) && (!ov_reg || out_ready);

    // sequencer
    always_comb
    begin
        st_next    = st_reg;
        k_next     = k_reg;
        ang_next   = ang_reg;
        nang_next  = nang_reg;
        sq_next    = sq_reg;
        sumsq_next = sumsq_reg;
        bsum_next  = bsum_reg;
        seen_next  = seen_reg;
        fault_next = fault_reg;
        sqrt_start = 1'b0;
        cord_start = 1'b0;
        in_ready   = 1'b0;
        unique case (st_reg)
            ica_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    k_next     = 2'd0;
                    sumsq_next = 64'd0;
                    fault_next = 1'b0;
                    if (gyro_valid)
                        st_next = ica_pkg::S_GMUL;
                    else if (accel_valid)
                        st_next = ica_pkg::S_SQMUL;
                    else
                        st_next = ica_pkg::S_DONE;
                end
            end
            ica_pkg::S_GMUL:
            begin
                st_next = ica_pkg::S_GACC;
            end
            ica_pkg::S_GACC:
            begin
                ang_next[k_reg] = ica_pkg::sat32(gsum);
                if (k_reg == 2'd2)
                begin
                    k_next  = 2'd0;
                    st_next = av_reg ? ica_pkg::S_SQMUL : ica_pkg::S_DONE;
                end
                else
                begin
                    k_next  = k_reg + 2'd1;
                    st_next = ica_pkg::S_GMUL;
                end
            end
            ica_pkg::S_SQMUL:
            begin
                st_next = ica_pkg::S_SQACC;
            end
            ica_pkg::S_SQACC:
            begin
                sq_next[k_reg] = prod_reg[63:0];
                sumsq_next     = sumsq_reg + prod_reg[63:0];
                if (k_reg == 2'd2)
                begin
                    k_next  = 2'd0;
                    st_next = ica_pkg::S_CHK;
                end
                else
                begin
                    k_next  = k_reg + 2'd1;
                    st_next = ica_pkg::S_SQMUL;
                end
            end
            ica_pkg::S_CHK:
            begin
                // zero magnitude: flag it and leave the angles alone
                if (sumsq_reg == 64'd0)
                begin
                    fault_next = 1'b1;
                    st_next    = ica_pkg::S_DONE;
                end
                else
                    st_next = ica_pkg::S_ROOT;
            end
            ica_pkg::S_ROOT:
            begin
                sqrt_start = 1'b1;
                st_next    = ica_pkg::S_ROOTW;
            end
            ica_pkg::S_ROOTW:
            begin
                if (sqrt_stat.done)
                    st_next = ica_pkg::S_CORD;
            end
            ica_pkg::S_CORD:
            begin
                cord_start = 1'b1;
                st_next    = ica_pkg::S_CORDW;
            end
            ica_pkg::S_CORDW:
            begin
                if (cord_stat.done)
                begin
                    nang_next[k_reg] = cord_angle;
                    if (k_reg == 2'd2)
                    begin
                        k_next  = 2'd0;
                        st_next = seen_reg ? ica_pkg::S_BMUL0 : ica_pkg::S_LOAD;
                    end
                    else
                    begin
                        k_next  = k_reg + 2'd1;
                        st_next = ica_pkg::S_ROOT;
                    end
                end
            end
            ica_pkg::S_LOAD:
            begin
                ang_next  = nang_reg;
                seen_next = 1'b1;
                st_next   = ica_pkg::S_DONE;
            end
            ica_pkg::S_BMUL0:
            begin
                st_next = ica_pkg::S_BMUL1;
            end
            ica_pkg::S_BMUL1:
            begin
                bsum_next = prod_reg[49:0];
                st_next   = ica_pkg::S_BACC;
            end
            ica_pkg::S_BACC:
            begin
                ang_next[k_reg] = ica_pkg::sat32(bsum_r);
                if (k_reg == 2'd2)
                begin
                    k_next  = 2'd0;
                    st_next = ica_pkg::S_DONE;
                end
                else
                begin
                    k_next  = k_reg + 2'd1;
                    st_next = ica_pkg::S_BMUL0;
                end
            end
            ica_pkg::S_DONE:
            begin
                if (!ov_reg || out_ready)
                    st_next = ica_pkg::S_IDLE;
            end
            default:
            begin
                st_next = ica_pkg::S_IDLE;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        ov_next = ov_reg;
        if (out_load)
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ica_pkg::S_IDLE;
            k_reg      <= 2'd0;
            ov_reg     <= 1'b0;
            seen_reg   <= 1'b0;
            ang_reg[0] <= 32'sd0;
            ang_reg[1] <= 32'sd0;
            ang_reg[2] <= 32'sd0;
        end
        else
        begin
            st_reg   <= st_next;
            k_reg    <= k_next;
            ov_reg   <= ov_next;
            seen_reg <= seen_next;
            ang_reg  <= ang_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        nang_reg  <= nang_next;
        sq_reg    <= sq_next;
        sumsq_reg <= sumsq_next;
        bsum_reg  <= bsum_next;
        fault_reg <= fault_next;
        if (accept)
        begin
            gv_reg <= gyro_valid;
            gx_reg <= gyro_x;
            gy_reg <= gyro_y;
            gz_reg <= gyro_z;
            dt_reg <= step_time;
            av_reg <= accel_valid;
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
        end
        if (out_load)
        begin
            roll_reg  <= ang_reg[0];
            yaw_reg   <= ang_reg[1];
            pitch_reg <= ang_reg[2];
            of_reg    <= fault_reg;
            os_reg    <= seen_reg;
        end
    end

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg <= ica_pkg::BLEND_RESET;
            bx_reg <= 32'sd0;
            by_reg <= 32'sd0;
            bz_reg <= 32'sd0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                ica_pkg::REG_BLEND:  bw_reg <= pwdata[16:0];
                ica_pkg::REG_BIAS_X: bx_reg <= pwdata;
                ica_pkg::REG_BIAS_Y: by_reg <= pwdata;
                ica_pkg::REG_BIAS_Z: bz_reg <= pwdata;
                default:             bw_reg <= bw_reg;
            endcase
        end
    end

    // config reads
    always_comb
    begin
        unique case (paddr[3:2])
            ica_pkg::REG_BLEND:  prdata = {15'd0, bw_reg};
            ica_pkg::REG_BIAS_X: prdata = bx_reg;
            ica_pkg::REG_BIAS_Y: prdata = by_reg;
            ica_pkg::REG_BIAS_Z: prdata = bz_reg;
            default:             prdata = 32'd0;
        endcase
    end

    ica_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sumsq_reg - sq_reg[k_reg]),
        .stat     (sqrt_stat),
        .root     (root)
    );

    ica_cordic #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .c     (acc_sel),
        .y0    ({1'b0, root}),
        .stat  (cord_stat),
        .angle (cord_angle)
    );

    assign out_valid   = ov_reg;
    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;
    assign accel_fault = of_reg;
    assign accel_seen  = os_reg;

    // the first accel load is sticky
    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(seen_reg))
        else $error("accel seen flag cleared");

    // square root and CORDIC never run together
    a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(sqrt_stat.busy && cord_stat.busy))
        else $error("shared units overlap");

    // fault is raised only on a zero magnitude of an accel sample
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ica_pkg::S_DONE && fault_reg) |-> (av_reg && sumsq_reg == 64'd0))
        else $error("accel fault without zero magnitude");

    // gyro path only entered for a gyro sample
    a_gyro_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ica_pkg::S_GMUL) |-> gv_reg)
        else $error("gyro update without gyro sample");

endmodule
